@@ design/rfp_pkg.sv @@
package rfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned DistW   = 16;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0]    FrameHeader      = 8'h5A;
  localparam logic [PosW-1:0]     LastBytePos      = 3'd7;
  localparam logic [PosW-1:0]     DistHighPos      = 3'd4;
  localparam logic [PosW-1:0]     DistLowPos       = 3'd5;
  localparam logic [PosW-1:0]     InfoPos          = 3'd6;
  localparam logic [StatusW-1:0]  StatusOutOfRange = 4'd2;
  localparam logic [DistW-1:0]    VibrateLimitMm   = 16'd1000;
  localparam logic [DistW-1:0]    ObstacleThrReset = 16'd300;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0]  CfgObstacleThr   = 1'b0;
  localparam logic [CfgIdxW-1:0]  CfgVibrateEn     = 1'b1;

  typedef struct packed {
    logic [DistW-1:0]   range_mm;
    logic               in_range;
    logic [StatusW-1:0] range_status;
    logic               obstacle;
    logic               vibrate;
  } rfp_result_t;

endpackage

@@ design/rfp_in_if.sv @@
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_restart;

  modport source (output valid, output rx_byte, output frame_restart, input ready);
  modport sink   (input valid, input rx_byte, input frame_restart, output ready);
endinterface

@@ design/rfp_out_if.sv @@
interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        in_range;
  logic [3:0]  range_status;
  logic        obstacle;
  logic        vibrate;

  modport source (output valid, output range_mm, output in_range, output range_status,
                  output obstacle, output vibrate, input ready);
  modport sink   (input valid, input range_mm, input in_range, input range_status,
                  input obstacle, input vibrate, output ready);
endinterface

@@ design/range_frame_parser.sv @@
// Channel   Dir  Beat payload                                               Handshake
// rx_i      in   rx_byte[7:0], frame_restart                                valid/ready
// res_o     out  range_mm[15:0], in_range, range_status[3:0], obstacle, vibrate  valid/ready
// cfg       in   cfg_idx_i, cfg_wdata_i[15:0]                               cfg_we_i
//
// One received byte per cycle. A good frame's result is registered on the
// edge that takes its checksum byte and is offered on res_o the next cycle.
// The single result register is the only storage between the sides: rx_i
// stays ready while it is empty or being drained in the same cycle, so
// bytes stream at full rate as long as results are taken.
// rst_ni (async, active low) clears the frame position and checksum and
// returns the config to threshold 300 mm, vibrate off.
module range_frame_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  rfp_in_if.sink                       rx_i,
  rfp_out_if.source                    res_o
);
  import rfp_pkg::*;

  // configuration
  logic [DistW-1:0] obst_thr_q;
  logic             vib_en_q;

  // frame assembly state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] dist_hi_q, dist_lo_q, info_q;

  // result register
  logic             res_valid_q, res_valid_d;
  rfp_result_t      res_q, res_d;

  logic             in_acc;
  logic [PosW-1:0]  pos_eff;
  logic [ByteW-1:0] sum_eff;
  logic             frame_good;
  logic [DistW-1:0] meas_mm;
  logic [StatusW-1:0] status;
  logic             rng_ok;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign in_acc     = rx_i.valid && rx_i.ready;

  // restart drops the partial frame before this byte is looked at
  assign pos_eff = rx_i.frame_restart ? '0 : pos_q;
  assign sum_eff = rx_i.frame_restart ? '0 : sum_q;

  assign frame_good = (pos_eff == LastBytePos) && (sum_eff == rx_i.rx_byte);
  assign meas_mm    = {dist_hi_q, dist_lo_q};
  assign status     = info_q[ByteW-1 -: StatusW];
  assign rng_ok     = (status != StatusOutOfRange);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (in_acc) begin
      if (pos_eff == '0) begin
        // hunt for the header; anything else is dropped
        if (rx_i.rx_byte == FrameHeader) begin
          pos_d = PosW'(1);
          sum_d = rx_i.rx_byte;
        end else begin
          pos_d = '0;
          sum_d = sum_eff;
        end
      end else if (pos_eff == LastBytePos) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_eff + PosW'(1);
        sum_d = sum_eff + rx_i.rx_byte;
      end
    end
  end

  always_comb begin
    res_d.range_status = status;
    res_d.in_range     = rng_ok;
    if (rng_ok) begin
      res_d.range_mm = meas_mm;
      res_d.obstacle = (meas_mm != '0) && (meas_mm < obst_thr_q);
      res_d.vibrate  = vib_en_q && (meas_mm < VibrateLimitMm);
    end else begin
      res_d.range_mm = '0;
      res_d.obstacle = 1'b0;
      res_d.vibrate  = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (in_acc && frame_good) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_thr_q <= ObstacleThrReset;
      vib_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgObstacleThr: obst_thr_q <= cfg_wdata_i;
        CfgVibrateEn:   vib_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      dist_hi_q   <= '0;
      dist_lo_q   <= '0;
      info_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      res_valid_q <= res_valid_d;
      if (in_acc) begin
        if (pos_eff == DistHighPos) dist_hi_q <= rx_i.rx_byte;
        if (pos_eff == DistLowPos)  dist_lo_q <= rx_i.rx_byte;
        if (pos_eff == InfoPos)     info_q    <= rx_i.rx_byte;
      end
    end
  end

  // result payload only loads on a good checksum beat
  always_ff @(posedge clk_i) begin
    if (in_acc && frame_good) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.range_mm     = res_q.range_mm;
  assign res_o.in_range     = res_q.in_range;
  assign res_o.range_status = res_q.range_status;
  assign res_o.obstacle     = res_q.obstacle;
  assign res_o.vibrate      = res_q.vibrate;

`ifndef SYNTHESIS
  a_res_from_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(in_acc && pos_eff == LastBytePos))
    else $error("result raised without a checksum beat");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.in_range) |->
      (res_q.range_mm == '0 && !res_q.obstacle && !res_q.vibrate))
    else $error("out-of-range result carries distance or flags");

  a_restart_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rx_i.frame_restart && rx_i.rx_byte != FrameHeader) |=> (pos_q == '0))
    else $error("restart did not drop the partial frame");

  a_obstacle_below_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.obstacle) |->
      (res_q.range_mm != '0 && res_q.range_mm < obst_thr_q))
    else $error("obstacle flagged outside threshold");
`endif

endmodule
